[rtl/core/lmbd_pkg.sv]
package lmbd_pkg;

   localparam int PIX_W     = 32;
   localparam int COORD_W   = 11;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_BACKGROUND   = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_idx_type;

   // per-word control decided at accept time, carried with the word
   typedef struct packed {
      logic emit;
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
      logic last;
   } ctl_type;

endpackage

[rtl/core/label_map_border_detect_core.sv]
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_pixel_word, req_flush
// rsp     | out       | rsp_valid/rsp_ready  | rsp_col, rsp_row, rsp_on_boundary, rsp_frame_last
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata (always ready)
//
// One word per cycle sustained while rsp_ready is high. A word is registered in the
// input stage (line store read completes) and is judged into the result register
// when it advances. The result for a pixel leaves frame_width+1 words after it.
// Synchronous reset clears counters, window and valids; line stores are not
// cleared. A full result register stalls the input stage only when the word
// there produces a result.
module label_map_border_detect_core
   import lmbd_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel_word,
   input  logic                 req_flush,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COORD_W-1:0]   rsp_col,
   output logic [COORD_W-1:0]   rsp_row,
   output logic                 rsp_on_boundary,
   output logic                 rsp_frame_last,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIX_W-1:0]     csr_wdata
);

   localparam int IW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int SZW0 = $clog2(MAX_WIDTH + 1);
   localparam int SZH0 = $clog2(MAX_HEIGHT + 1);
   localparam int SZW  = (SZW0 > CFG_W) ? SZW0 : CFG_W;
   localparam int SZH  = (SZH0 > CFG_W) ? SZH0 : CFG_W;
   localparam int MW   = 2 * PIX_W;

   // configuration
   logic [CFG_W-1:0] frame_width_ff, frame_height_ff;
   logic [PIX_W-1:0] background_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_W'(640);
         frame_height_ff <= CFG_W'(480);
         background_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[CFG_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[CFG_W-1:0];
            CSR_BACKGROUND:   background_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped sizes
   logic [SZW-1:0] fw_ext, w_eff;
   logic [SZH-1:0] fh_ext, h_eff;

   always_comb begin
      fw_ext = SZW'(frame_width_ff);
      fh_ext = SZH'(frame_height_ff);
      if (fw_ext == '0)                 w_eff = SZW'(1);
      else if (fw_ext > SZW'(MAX_WIDTH)) w_eff = SZW'(MAX_WIDTH);
      else                              w_eff = fw_ext;
      if (fh_ext == '0)                  h_eff = SZH'(1);
      else if (fh_ext > SZH'(MAX_HEIGHT)) h_eff = SZH'(MAX_HEIGHT);
      else                               h_eff = fh_ext;
   end

   // handshake
   logic a_valid_ff, a_valid_in;
   ctl_type a_ctl_ff, a_ctl_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, advance, out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = a_valid_ff && (!a_ctl_ff.emit || out_free);
   assign req_ready = !a_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // position counters, advanced at accept; pixel data plays no part
   logic [IW-1:0] in_col_ff, in_col_in;
   logic [1:0]    in_row_ff, in_row_in;   // saturates at 2
   logic [IW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [IW:0]   in_col_inc, out_col_inc;
   logic [RW:0]   out_row_inc;

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      in_col_inc  = {1'b0, in_col_ff} + 1'b1;
      out_col_inc = {1'b0, out_col_ff} + 1'b1;
      out_row_inc = {1'b0, out_row_ff} + 1'b1;
      a_ctl_in.emit     = (in_row_ff == 2'd2) || (in_row_ff == 2'd1 && in_col_ff != '0);
      a_ctl_in.top_ok   = (out_row_ff != '0);
      a_ctl_in.left_ok  = (out_col_ff != '0);
      a_ctl_in.bot_ok   = SZH'(out_row_inc) < h_eff;
      a_ctl_in.right_ok = SZW'(out_col_inc) < w_eff;
      a_ctl_in.last     = !a_ctl_in.bot_ok && !a_ctl_in.right_ok;

      if (SZW'(in_col_inc) >= w_eff) begin
         in_col_in = '0;
         if (in_row_ff != 2'd2) in_row_in = in_row_ff + 2'd1;
      end else begin
         in_col_in = in_col_inc[IW-1:0];
      end

      if (a_ctl_in.emit) begin
         if (a_ctl_in.last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (!a_ctl_in.right_ok) begin
            out_col_in = '0;
            out_row_in = out_row_inc[RW-1:0];
         end else begin
            out_col_in = out_col_inc[IW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // input stage
   logic [PIX_W-1:0] a_pix_ff;
   logic [IW-1:0]    a_idx_ff;
   logic [IW-1:0]    a_col_ff;
   logic [RW-1:0]    a_row_ff;

   assign a_valid_in = accept ? 1'b1 : (advance ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_ctl_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (accept) a_ctl_ff <= a_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff <= req_pixel_word;
         a_idx_ff <= in_col_ff;
         a_col_ff <= out_col_ff;
         a_row_ff <= out_row_ff;
      end
   end

   // line stores: one word holds {second-newest, newest} per column
   logic [MW-1:0] line_mem [MAX_WIDTH];
   logic [MW-1:0] rd_data_ff;
   logic [MW-1:0] fwd_data_ff;
   logic          fwd_hit_ff;
   logic [MW-1:0] line_cur, line_wr;

   assign line_cur = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign line_wr  = {line_cur[PIX_W-1:0], a_pix_ff};

   always_ff @(posedge clock) begin
      if (advance) line_mem[a_idx_ff] <= line_wr;
      if (accept)  rd_data_ff <= line_mem[in_col_ff];
   end

   // same column written and read on one edge (narrow frames): forward
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (accept) begin
         fwd_hit_ff <= advance && (a_idx_ff == in_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) fwd_data_ff <= line_wr;
   end

   // 3x3 window, index r*3+c
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3+0] = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = line_cur[MW-1:PIX_W];
      win_in[5] = line_cur[PIX_W-1:0];
      win_in[8] = a_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (advance) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= win_in[i];
      end
   end

   // border decision on the shifted window
   logic [2:0] row_ok, col_ok;
   logic       border;

   always_comb begin
      row_ok = {a_ctl_ff.bot_ok, 1'b1, a_ctl_ff.top_ok};
      col_ok = {a_ctl_ff.right_ok, 1'b1, a_ctl_ff.left_ok};
      border = 1'b0;
      if (win_in[4] != background_ff) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c] &&
                   win_in[r*3+c] != win_in[4] && win_in[r*3+c] != background_ff)
                  border = 1'b1;
            end
         end
      end
   end

   // result register
   logic [IW+COORD_W-1:0] col_ext;
   logic [RW+COORD_W-1:0] row_ext;
   logic [COORD_W-1:0]    col_ff, row_ff;
   logic                  border_ff, last_ff;
   logic                  load_rsp;

   assign col_ext  = {{COORD_W{1'b0}}, a_col_ff};
   assign row_ext  = {{COORD_W{1'b0}}, a_row_ff};
   assign load_rsp = advance && a_ctl_ff.emit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         col_ff    <= col_ext[COORD_W-1:0];
         row_ff    <= row_ext[COORD_W-1:0];
         border_ff <= border;
         last_ff   <= a_ctl_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_col         = col_ff;
   assign rsp_row         = row_ff;
   assign rsp_on_boundary = border_ff;
   assign rsp_frame_last  = last_ff;

endmodule

[tb/tb_top.sv]
module tb_top
   import lmbd_pkg::*;
();

   localparam int MAX_W         = 2048;
   localparam int MAX_H         = 2048;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 420;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               on_boundary;
      logic               frame_last;
   } verdict_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel_word;
   logic                 req_flush;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [COORD_W-1:0]   rsp_col;
   logic [COORD_W-1:0]   rsp_row;
   logic                 rsp_on_boundary;
   logic                 rsp_frame_last;
   logic                 csr_valid;
   logic                 csr_ready;
   csr_idx_type          csr_index;
   logic [PIX_W-1:0]     csr_wdata;

   // predictor state
   bit [PIX_W-1:0]       near_line [MAX_W];
   bit [PIX_W-1:0]       far_line [MAX_W];
   bit [PIX_W-1:0]       win [9];
   int unsigned          in_col;
   int unsigned          in_row;
   int unsigned          out_col;
   int unsigned          out_row;
   logic [CFG_W-1:0]     cfg_width;
   logic [CFG_W-1:0]     cfg_height;
   logic [PIX_W-1:0]     cfg_background;

   verdict_type          pending_verdicts [$];
   int unsigned          err_count;
   int unsigned          items_sent;
   int unsigned          cycle_count;
   int unsigned          rsp_hold;
   bit                   steady;
   logic [PIX_W-1:0]     palette [4];
   bit [PIX_W-1:0]       row_above [MAX_W];

   label_map_border_detect_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_word  (req_pixel_word),
      .req_flush       (req_flush),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_col         (rsp_col),
      .rsp_row         (rsp_row),
      .rsp_on_boundary (rsp_on_boundary),
      .rsp_frame_last  (rsp_frame_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic int unsigned draw_gap();
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   // advance the window by one word and queue the verdict it completes, if any
   task automatic judge_pixel(input logic [PIX_W-1:0] pix);
      int unsigned w, h, idx;
      int r, c;
      bit emit, border, last, in_view;
      bit [PIX_W-1:0] centre;
      verdict_type v;
      w = clamp_size(cfg_width, MAX_W);
      h = clamp_size(cfg_height, MAX_H);
      idx = (in_col >= MAX_W) ? MAX_W - 1 : in_col;
      for (r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = far_line[idx];
      win[5] = near_line[idx];
      win[8] = pix;
      far_line[idx]  = near_line[idx];
      near_line[idx] = pix;

      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return;

      centre = win[4];
      border = 1'b0;
      if (centre != cfg_background) begin
         for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
               in_view = !(r == 1 && c == 1) && !(r == 0 && out_row == 0) &&
                         !(r == 2 && out_row + 1 >= h) && !(c == 0 && out_col == 0) &&
                         !(c == 2 && out_col + 1 >= w);
               if (in_view && win[r*3+c] != centre && win[r*3+c] != cfg_background)
                  border = 1'b1;
            end
         end
      end
      last = (out_col + 1 >= w) && (out_row + 1 >= h);
      v.col         = COORD_W'(out_col);
      v.row         = COORD_W'(out_row);
      v.on_boundary = border;
      v.frame_last  = last;
      pending_verdicts.push_back(v);

      if (last) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   // valid stays high into the next word when no gap is drawn
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic flush);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_word <= pix;
      req_flush      <= flush;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      judge_pixel(pix);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // pad with dummy words until the block sits at a frame boundary
   task automatic close_frame();
      while (in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0)
         send_pixel($urandom, 1'b1);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [PIX_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width = data[CFG_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = data[CFG_W-1:0];
         CSR_BACKGROUND:   cfg_background = data;
         default: ;
      endcase
   endtask

   task automatic configure_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                  input logic [PIX_W-1:0] bg);
      close_frame();
      settle_block();
      // upper bits of the size words are don't-care
      write_csr(CSR_FRAME_WIDTH, {20'($urandom), w});
      write_csr(CSR_FRAME_HEIGHT, {20'($urandom), h});
      write_csr(CSR_BACKGROUND, bg);
      csr_valid <= 1'b0;
   endtask

   // one full frame of blobby regions plus the trailing width+1 dummy words
   task automatic send_frame(input bit noisy);
      int unsigned w, h, r, c, pick, i;
      logic [PIX_W-1:0] pix;
      w = clamp_size(cfg_width, MAX_W);
      h = clamp_size(cfg_height, MAX_H);
      palette[0] = cfg_background;
      for (i = 1; i < 4; i++) begin
         case ($urandom_range(0, 5))
            0:       palette[i] = 32'h0;
            1:       palette[i] = 32'hFFFF_FFFF;
            default: palette[i] = $urandom;
         endcase
      end
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            pick = $urandom_range(0, 99);
            if (c != 0 && pick < 40) pix = row_above[c-1];
            else if (r != 0 && pick < 70) pix = row_above[c];
            else if (pick < 96) pix = palette[$urandom_range(0, 3)];
            else pix = $urandom;
            row_above[c] = pix;
            send_pixel(pix, noisy && ($urandom_range(0, 9) == 0));
         end
      end
      repeat (w + 1) send_pixel($urandom, !(noisy && ($urandom_range(0, 9) == 0)));
   endtask

   task automatic test_directed();
      logic [PIX_W-1:0] grid [9];
      grid = '{32'h1, 32'h1, 32'hFFFF_FFFF,
               32'h1, 32'h0, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'h1, 32'h1};
      configure_frame(12'd3, 12'd3, 32'h0);
      foreach (grid[i]) send_pixel(grid[i], 1'b0);
      send_pixel(32'h0, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h0, 1'b0);
      send_pixel(32'h0, 1'b1);
      // flush bit set on a real pixel has no effect
      configure_frame(12'd2, 12'd2, 32'hFFFF_FFFF);
      send_pixel(32'h0, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h5, 1'b0);
      send_pixel(32'h5, 1'b0);
      repeat (3) send_pixel(32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_frame_sizes();
      configure_frame(12'd0, 12'd0, 32'h0);
      send_frame(1'b1);
      send_frame(1'b0);
      configure_frame(12'd1, 12'd6, $urandom);
      send_frame(1'b1);
      configure_frame(12'd7, 12'd1, 32'h0);
      send_frame(1'b1);
   endtask

   task automatic test_background_values();
      configure_frame(12'd5, 12'd4, 32'h0);
      send_frame(1'b0);
      send_frame(1'b1);
      configure_frame(12'd5, 12'd4, 32'hFFFF_FFFF);
      send_frame(1'b0);
      send_frame(1'b1);
      configure_frame(12'd4, 12'd4, $urandom);
      send_frame(1'b1);
   endtask

   task automatic test_unused_register();
      close_frame();
      settle_block();
      write_csr(CSR_UNUSED, $urandom);
      csr_valid <= 1'b0;
      send_frame(1'b1);
      send_frame(1'b0);
   endtask

   task automatic test_random_frames();
      int unsigned start, phase;
      start = items_sent;
      phase = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         configure_frame(($urandom_range(0, 4) == 0) ? 12'($urandom_range(10, 40))
                                                      : 12'($urandom_range(0, 9)),
                         12'($urandom_range(0, 7)),
                         ($urandom_range(0, 1) != 0) ? $urandom : 32'h0);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 30)) send_pixel($urandom, 1'($urandom_range(0, 1)));
            else
               send_frame(1'b1);
         end
         if (phase == 1) begin
            // stop partway into a frame and let everything drain
            repeat (5) send_pixel($urandom, 1'b0);
            settle_block();
         end
         phase++;
      end
      steady = 1'b0;
   endtask

   // receiver: fresh stall per word
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_ready && rsp_valid) begin
         rsp_hold = draw_gap();
         if (rsp_hold != 0) rsp_ready <= 1'b0;
      end else if (!rsp_ready) begin
         if (rsp_hold > 0) rsp_hold--;
         if (rsp_hold == 0) rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected result word: col %0d row %0d", rsp_col, rsp_row);
            err_count++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("col", 32'(want.col), 32'(rsp_col));
            check_field("row", 32'(want.row), 32'(rsp_row));
            check_field("on_boundary", 32'(want.on_boundary), 32'(rsp_on_boundary));
            check_field("frame_last", 32'(want.frame_last), 32'(rsp_frame_last));
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_word = '0;
      req_flush      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_FRAME_WIDTH;
      csr_wdata      = '0;
      cfg_width      = 12'd640;
      cfg_height     = 12'd480;
      cfg_background = 32'h0;
      in_col         = 0;
      in_row         = 0;
      out_col        = 0;
      out_row        = 0;
      err_count      = 0;
      items_sent     = 0;
      steady         = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_frame_sizes();
      test_background_values();
      test_unused_register();
      test_random_frames();

      close_frame();
      settle_block();
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[label_map_border_detect_core.f]
rtl/core/lmbd_pkg.sv
rtl/core/label_map_border_detect_core.sv
tb/tb_top.sv
